>>> hw/rtl/chull_pkg.sv
// package: shared constants, types and state encoding for the convex hull block
package chull_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int MIN_SET = 3;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_FEW = 2'd1;
  localparam logic [1:0] STATUS_OVER = 2'd2;

  typedef enum logic [4:0] {
    S_LOAD,
    S_PIV_RD,
    S_PIV_CMP,
    S_ORD_INIT,
    S_SORT_I,
    S_SORT_RDA,
    S_SORT_RDB,
    S_SORT_RDC,
    S_SORT_PB,
    S_SORT_X,
    S_SORT_D,
    S_SORT_CMP,
    S_SORT_WR,
    S_SORT_WR2,
    S_SCAN_INIT,
    S_SCAN_INIT1,
    S_SCAN_INIT2,
    S_SCAN_I,
    S_SCAN_RDC,
    S_SCAN_PC,
    S_SCAN_TEST,
    S_SCAN_RDP,
    S_SCAN_RDQ,
    S_SCAN_PQ,
    S_SCAN_X,
    S_SCAN_CMP,
    S_SCAN_PUSH,
    S_EMIT_RD,
    S_EMIT_OUT,
    S_ERR_OUT
  } state_t;

  // operand select for the shared unit
  typedef enum logic [1:0] {
    OP_CROSS,
    OP_DIST
  } op_t;

endpackage

>>> hw/rtl/chull_if.sv
// interfaces: point input channel and hull result channel
interface chull_in_if #(
  parameter int COORD_BITS = chull_pkg::COORD_BITS
);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic last_point;
  modport source (output valid, px, py, last_point, input ready);
  modport sink (input valid, px, py, last_point, output ready);
endinterface

interface chull_out_if;
  logic valid;
  logic ready;
  logic [5:0] hull_index;
  logic [6:0] hull_count;
  logic last_result;
  logic [1:0] status;
  modport source (output valid, hull_index, hull_count, last_result, status, input ready);
  modport sink (input valid, hull_index, hull_count, last_result, status, output ready);
endinterface

>>> hw/rtl/convex_hull_2d.sv
// top level: point loader, sequencer and shared unit for the Graham scan hull
// Points are taken one per cycle while loading; the transaction with last_point
// set starts the hull build, and the input is not ready until every result has
// been taken. The build walks the point memory with one shared two-stage
// multiplier unit: the pivot search, the order list, then an insertion sort with
// at most (n-1)(n-2)/2 compares, then the scan with at most 2n turn tests, then
// the output of one hull result per cycle while the sink is ready. The sort
// dominates in the worst case. Error sets are answered in the cycle after the
// last point. Collinear or repeated points can leave a hull of two points.
module convex_hull_2d #(
  parameter int MAX_POINTS = chull_pkg::MAX_POINTS,
  parameter int COORD_BITS = chull_pkg::COORD_BITS
) (
  input  logic clk,
  input  logic rst,
  chull_in_if.sink    in_ch,
  chull_out_if.source out_ch
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = AW + 1;
  localparam int PTW = 2 * COORD_BITS;
  localparam int DW = COORD_BITS + 1;

  chull_pkg::state_t state, state_next;

  logic [CW-1:0] cnt, cnt_next;
  logic          over, over_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [CW-1:0] top, top_next;
  logic [AW-1:0] bottom, bottom_next;
  logic signed [COORD_BITS-1:0] ox, oy, ox_next, oy_next;
  logic [AW-1:0] ia, ib, ic, ia_next, ib_next, ic_next;
  logic signed [COORD_BITS-1:0] ax_r, ay_r, bx_r, by_r;
  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic [1:0] err_code, err_code_next;

  // memories
  logic pt_we; logic [AW-1:0] pt_wa, pt_ra; logic [PTW-1:0] pt_wd, pt_rd;
  logic od_we; logic [AW-1:0] od_wa, od_ra; logic [AW-1:0] od_wd, od_rd;
  logic hs_we; logic [AW-1:0] hs_wa, hs_ra; logic [AW-1:0] hs_wd, hs_rd;

  chull_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_pts (
    .clk, .we(pt_we), .waddr(pt_wa), .wdata(pt_wd), .raddr(pt_ra), .rdata(pt_rd));
  chull_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_ord (
    .clk, .we(od_we), .waddr(od_wa), .wdata(od_wd), .raddr(od_ra), .rdata(od_rd));
  chull_ram #(.WIDTH(AW), .DEPTH(MAX_POINTS)) u_stk (
    .clk, .we(hs_we), .waddr(hs_wa), .wdata(hs_wd), .raddr(hs_ra), .rdata(hs_rd));

  logic signed [COORD_BITS-1:0] rx, ry;
  assign rx = pt_rd[PTW-1:COORD_BITS];
  assign ry = pt_rd[COORD_BITS-1:0];

  // shared unit
  chull_pkg::op_t op;
  logic signed [COORD_BITS:0] u_ax, u_ay, u_bx, u_by;
  logic u_neg, u_zero;
  chull_alu #(.COORD_BITS(COORD_BITS)) u_alu (
    .clk, .op, .ax(u_ax), .ay(u_ay), .bx(u_bx), .by(u_by), .neg(u_neg), .zero(u_zero));

  logic out_acc;
  assign out_acc = out_ch.valid && out_ch.ready;

  // operand formation: sort uses vectors from pivot, scan uses q-p and c-q
  always_comb begin
    if (state == chull_pkg::S_SORT_X) begin
      // cross(b-o, a-o)
      op = chull_pkg::OP_CROSS;
      u_ax = DW'(bx_r) - DW'(ox);
      u_ay = DW'(by_r) - DW'(oy);
      u_bx = DW'(ax_r) - DW'(ox);
      u_by = DW'(ay_r) - DW'(oy);
    end else if (state == chull_pkg::S_SORT_D) begin
      // dist(a-o) against dist(b-o)
      op = chull_pkg::OP_DIST;
      u_ax = DW'(ax_r) - DW'(ox);
      u_ay = DW'(ay_r) - DW'(oy);
      u_bx = DW'(bx_r) - DW'(ox);
      u_by = DW'(by_r) - DW'(oy);
    end else begin
      // a = p, b = q, c = current
      op = chull_pkg::OP_CROSS;
      u_ax = DW'(bx_r) - DW'(ax_r);
      u_ay = DW'(by_r) - DW'(ay_r);
      u_bx = DW'(cx_r) - DW'(bx_r);
      u_by = DW'(cy_r) - DW'(by_r);
    end
  end

  // result of the cross pass kept for the combined sort decision
  logic cr_neg, cr_zero;

  // state and data registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chull_pkg::S_LOAD;
      cnt <= '0;
      over <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      over <= over_next;
    end
    i <= i_next; j <= j_next; top <= top_next;
    bottom <= bottom_next; ox <= ox_next; oy <= oy_next;
    ia <= ia_next; ib <= ib_next; ic <= ic_next;
    err_code <= err_code_next;
  end

  // capture read data and the cross sign into operand registers
  always_ff @(posedge clk) begin
    case (state)
      chull_pkg::S_SORT_RDC, chull_pkg::S_SCAN_RDQ: begin
        ax_r <= rx; ay_r <= ry;
      end
      chull_pkg::S_SORT_PB, chull_pkg::S_SCAN_PQ: begin
        bx_r <= rx; by_r <= ry;
      end
      chull_pkg::S_SCAN_PC: begin
        cx_r <= rx; cy_r <= ry;
      end
      chull_pkg::S_SORT_D: begin
        cr_neg <= u_neg; cr_zero <= u_zero;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    cnt_next = cnt; over_next = over;
    i_next = i; j_next = j; top_next = top;
    bottom_next = bottom; ox_next = ox; oy_next = oy;
    ia_next = ia; ib_next = ib; ic_next = ic; err_code_next = err_code;
    pt_we = 1'b0; pt_wa = cnt[AW-1:0];
    pt_wd = {in_ch.px, in_ch.py};
    pt_ra = i[AW-1:0];
    od_we = 1'b0; od_wa = i[AW-1:0]; od_wd = i[AW-1:0]; od_ra = i[AW-1:0];
    hs_we = 1'b0; hs_wa = top[AW-1:0]; hs_wd = ic; hs_ra = i[AW-1:0];
    in_ch.ready = 1'b0;
    out_ch.valid = 1'b0;
    out_ch.hull_index = 6'(hs_rd);
    out_ch.hull_count = 7'(top);
    out_ch.last_result = (i + CW'(1) == top);
    out_ch.status = chull_pkg::STATUS_OK;
    unique case (state)
      chull_pkg::S_LOAD: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (cnt < CW'(MAX_POINTS)) begin
            pt_we = 1'b1;
            cnt_next = cnt + CW'(1);
          end else begin
            over_next = 1'b1;
          end
          if (in_ch.last_point) begin
            if (over || cnt >= CW'(MAX_POINTS)) begin
              err_code_next = chull_pkg::STATUS_OVER;
              state_next = chull_pkg::S_ERR_OUT;
            end else if (cnt + CW'(1) < CW'(chull_pkg::MIN_SET)) begin
              err_code_next = chull_pkg::STATUS_FEW;
              state_next = chull_pkg::S_ERR_OUT;
            end else begin
              i_next = '0;
              bottom_next = '0;
              state_next = chull_pkg::S_PIV_RD;
            end
          end
        end
      end
      chull_pkg::S_ERR_OUT: begin
        out_ch.valid = 1'b1;
        out_ch.hull_index = '0;
        out_ch.hull_count = '0;
        out_ch.last_result = 1'b1;
        out_ch.status = err_code;
        if (out_acc) begin
          cnt_next = '0; over_next = 1'b0;
          state_next = chull_pkg::S_LOAD;
        end
      end
      // pivot search: read point i, compare next cycle
      chull_pkg::S_PIV_RD: begin
        state_next = chull_pkg::S_PIV_CMP;
      end
      chull_pkg::S_PIV_CMP: begin
        if (i == '0 || ry < oy || (ry == oy && rx < ox)) begin
          bottom_next = i[AW-1:0]; ox_next = rx; oy_next = ry;
        end
        i_next = i + CW'(1);
        if (i + CW'(1) == cnt) begin
          i_next = '0;
          state_next = chull_pkg::S_ORD_INIT;
        end else begin
          state_next = chull_pkg::S_PIV_RD;
        end
      end
      // order list: identity with pivot swapped into slot zero
      chull_pkg::S_ORD_INIT: begin
        od_we = 1'b1;
        od_wd = (i == '0) ? bottom : ((i[AW-1:0] == bottom) ? '0 : i[AW-1:0]);
        i_next = i + CW'(1);
        if (i + CW'(1) == cnt) begin
          i_next = CW'(2);
          state_next = chull_pkg::S_SORT_I;
        end
      end
      chull_pkg::S_SORT_I: begin
        if (i >= cnt) begin
          state_next = chull_pkg::S_SCAN_INIT;
        end else begin
          j_next = i;
          state_next = chull_pkg::S_SORT_RDA;
        end
      end
      // read order[j], then order[j-1], then both points
      chull_pkg::S_SORT_RDA: begin
        od_ra = j[AW-1:0];
        state_next = chull_pkg::S_SORT_RDB;
      end
      chull_pkg::S_SORT_RDB: begin
        ia_next = od_rd;
        pt_ra = od_rd;
        od_ra = j[AW-1:0] - AW'(1);
        state_next = chull_pkg::S_SORT_RDC;
      end
      chull_pkg::S_SORT_RDC: begin
        ib_next = od_rd;
        pt_ra = od_rd;
        state_next = chull_pkg::S_SORT_PB;
      end
      chull_pkg::S_SORT_PB: begin
        state_next = chull_pkg::S_SORT_X;
      end
      chull_pkg::S_SORT_X: begin
        state_next = chull_pkg::S_SORT_D;
      end
      chull_pkg::S_SORT_D: begin
        state_next = chull_pkg::S_SORT_CMP;
      end
      // swap when a is clockwise of b, or collinear and a nearer
      chull_pkg::S_SORT_CMP: begin
        if (cr_neg || (cr_zero && u_neg)) begin
          state_next = chull_pkg::S_SORT_WR;
        end else begin
          i_next = i + CW'(1);
          state_next = chull_pkg::S_SORT_I;
        end
      end
      chull_pkg::S_SORT_WR: begin
        od_we = 1'b1;
        od_wa = j[AW-1:0]; od_wd = ib;
        state_next = chull_pkg::S_SORT_WR2;
      end
      chull_pkg::S_SORT_WR2: begin
        od_we = 1'b1;
        od_wa = j[AW-1:0] - AW'(1); od_wd = ia;
        if (j > CW'(2)) begin
          j_next = j - CW'(1);
          state_next = chull_pkg::S_SORT_RDA;
        end else begin
          i_next = i + CW'(1);
          state_next = chull_pkg::S_SORT_I;
        end
      end
      // stack starts with the first two sorted points
      chull_pkg::S_SCAN_INIT: begin
        od_ra = '0;
        state_next = chull_pkg::S_SCAN_INIT1;
      end
      chull_pkg::S_SCAN_INIT1: begin
        od_ra = AW'(1);
        hs_we = 1'b1; hs_wa = '0; hs_wd = od_rd;
        state_next = chull_pkg::S_SCAN_INIT2;
      end
      chull_pkg::S_SCAN_INIT2: begin
        hs_we = 1'b1; hs_wa = AW'(1); hs_wd = od_rd;
        top_next = CW'(2);
        i_next = CW'(2);
        state_next = chull_pkg::S_SCAN_I;
      end
      chull_pkg::S_SCAN_I: begin
        if (i >= cnt) begin
          i_next = '0;
          state_next = chull_pkg::S_EMIT_RD;
        end else begin
          state_next = chull_pkg::S_SCAN_RDC;
        end
      end
      chull_pkg::S_SCAN_RDC: begin
        ic_next = od_rd;
        pt_ra = od_rd;
        state_next = chull_pkg::S_SCAN_PC;
      end
      chull_pkg::S_SCAN_PC: begin
        state_next = chull_pkg::S_SCAN_TEST;
      end
      // turn test on the two top stack entries
      chull_pkg::S_SCAN_TEST: begin
        if (top <= CW'(1)) begin
          state_next = chull_pkg::S_SCAN_PUSH;
        end else begin
          hs_ra = top[AW-1:0] - AW'(2);
          state_next = chull_pkg::S_SCAN_RDP;
        end
      end
      chull_pkg::S_SCAN_RDP: begin
        pt_ra = hs_rd;
        hs_ra = top[AW-1:0] - AW'(1);
        state_next = chull_pkg::S_SCAN_RDQ;
      end
      chull_pkg::S_SCAN_RDQ: begin
        pt_ra = hs_rd;
        state_next = chull_pkg::S_SCAN_PQ;
      end
      chull_pkg::S_SCAN_PQ: begin
        state_next = chull_pkg::S_SCAN_X;
      end
      chull_pkg::S_SCAN_X: begin
        state_next = chull_pkg::S_SCAN_CMP;
      end
      chull_pkg::S_SCAN_CMP: begin
        if (u_neg || u_zero) begin
          top_next = top - CW'(1);
          state_next = chull_pkg::S_SCAN_TEST;
        end else begin
          state_next = chull_pkg::S_SCAN_PUSH;
        end
      end
      chull_pkg::S_SCAN_PUSH: begin
        hs_we = 1'b1;
        top_next = top + CW'(1);
        i_next = i + CW'(1);
        state_next = chull_pkg::S_SCAN_I;
      end
      // emit stack entries; read ahead on each accepted result
      chull_pkg::S_EMIT_RD: begin
        state_next = chull_pkg::S_EMIT_OUT;
      end
      chull_pkg::S_EMIT_OUT: begin
        out_ch.valid = 1'b1;
        if (out_acc) begin
          if (i + CW'(1) == top) begin
            cnt_next = '0; over_next = 1'b0;
            state_next = chull_pkg::S_LOAD;
          end else begin
            i_next = i + CW'(1);
            hs_ra = i[AW-1:0] + AW'(1);
          end
        end
      end
      default: begin
        state_next = chull_pkg::S_LOAD;
      end
    endcase
  end
endmodule

>>> hw/rtl/chull_ram.sv
// generic single-port-write, single-read ram with registered read
module chull_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/chull_alu.sv
// shared arithmetic unit: cross product or squared distance difference, two stages
module chull_alu #(
  parameter int COORD_BITS = chull_pkg::COORD_BITS
) (
  input  logic                         clk,
  input  chull_pkg::op_t               op,
  input  logic signed [COORD_BITS:0]   ax,
  input  logic signed [COORD_BITS:0]   ay,
  input  logic signed [COORD_BITS:0]   bx,
  input  logic signed [COORD_BITS:0]   by,
  output logic                         neg,
  output logic                         zero
);
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int SW = PW + 1;

  logic signed [PW-1:0] m0, m1, m2, m3;
  logic signed [PW-1:0] p0, p1;
  logic signed [SW-1:0] res;

  // four multipliers, first two routed by operation
  always_comb begin
    if (op == chull_pkg::OP_CROSS) begin
      m0 = PW'(ax) * PW'(by);
      m1 = PW'(ay) * PW'(bx);
    end else begin
      m0 = PW'(ax) * PW'(ax);
      m1 = PW'(ay) * PW'(ay);
    end
    m2 = PW'(bx) * PW'(bx);
    m3 = PW'(by) * PW'(by);
  end

  // stage one: registered partial terms
  always_ff @(posedge clk) begin
    if (op == chull_pkg::OP_CROSS) begin
      p0 <= m0;
      p1 <= m1;
    end else begin
      p0 <= m0 + m1 - m2;
      p1 <= m3;
    end
  end

  // stage two: difference and sign
  always_comb res = SW'(p0) - SW'(p1);
  assign neg = res[SW-1];
  assign zero = (res == '0);
endmodule

>>> hw/rtl/chull_checker.sv
// checker: port-level properties of the hull block, bound to the top level
module chull_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic [6:0] out_count,
  input logic [1:0] out_status
);
  // input is never ready while a result is offered
  a_excl: assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input ready while result pending");
  // error results are single and carry a zero count
  a_err: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != chull_pkg::STATUS_OK) |-> (out_last && out_count == 7'd0))
    else $error("malformed error result");
  // ok results report at least two hull points
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == chull_pkg::STATUS_OK) |-> (out_count >= 7'd2))
    else $error("hull count too small");
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_count) && $stable(out_status)))
    else $error("stalled result changed");
endmodule

bind convex_hull_2d chull_checker u_chk (
  .clk, .rst,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_last(out_ch.last_result), .out_count(out_ch.hull_count),
  .out_status(out_ch.status)
);

>>> test/tb_chull_if.sv
// testbench channel interfaces come from the shared rtl interface file
`timescale 1ns / 100ps

>>> test/tb.sv
// testbench: random and directed point sets checked against a graham scan predictor
`timescale 1ns / 100ps
module tb;

  typedef struct packed {
    logic [5:0] hull_index;
    logic [6:0] hull_count;
    logic       last_result;
    logic [1:0] status;
  } hull_res_t;

  // hull predictor and queue of expected hull results
  class hull_scoreboard;
    longint xs[chull_pkg::MAX_POINTS];
    longint ys[chull_pkg::MAX_POINTS];
    int count;
    bit overflow;
    hull_res_t pending[$];
    int errors;

    function void push_error(logic [1:0] code);
      hull_res_t r;
      r.hull_index = '0;
      r.hull_count = '0;
      r.last_result = 1'b1;
      r.status = code;
      pending.push_back(r);
    endfunction

    // sign of ax*by - ay*bx, exact in 64 bits for 17-bit deltas
    function int turn(longint ax, longint ay, longint bx, longint by);
      longint c;
      c = ax * by - ay * bx;
      return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
    endfunction

    function void solve_hull();
      int order[chull_pkg::MAX_POINTS];
      int stack[chull_pkg::MAX_POINTS];
      int piv, top, a, b, cc, p, q, sgn, tmp;
      longint ox, oy, x1, y1, x2, y2;
      hull_res_t r;
      piv = 0;
      for (int i = 1; i < count; i++)
        if (ys[i] < ys[piv] || (ys[i] == ys[piv] && xs[i] < xs[piv])) piv = i;
      for (int i = 0; i < count; i++) order[i] = i;
      order[piv] = order[0];
      order[0] = piv;
      ox = xs[piv];
      oy = ys[piv];
      // insertion sort by polar angle, nearer first on collinear
      for (int i = 2; i < count; i++) begin
        for (int j = i; j > 1; j--) begin
          a = order[j];
          b = order[j-1];
          x1 = xs[a] - ox; y1 = ys[a] - oy;
          x2 = xs[b] - ox; y2 = ys[b] - oy;
          sgn = turn(x2, y2, x1, y1);
          if (sgn < 0 || (sgn == 0 && (x1*x1 + y1*y1 < x2*x2 + y2*y2))) begin
            tmp = order[j]; order[j] = order[j-1]; order[j-1] = tmp;
          end else break;
        end
      end
      // scan, popping on any non-left turn
      top = 0;
      stack[top++] = order[0];
      stack[top++] = order[1];
      for (int i = 2; i < count; i++) begin
        cc = order[i];
        while (top > 1) begin
          p = stack[top-2];
          q = stack[top-1];
          if (turn(xs[q]-xs[p], ys[q]-ys[p], xs[cc]-xs[q], ys[cc]-ys[q]) <= 0) top--;
          else break;
        end
        stack[top++] = cc;
      end
      for (int i = 0; i < top; i++) begin
        r.hull_index = 6'(stack[i]);
        r.hull_count = 7'(top);
        r.last_result = (i + 1 == top);
        r.status = chull_pkg::STATUS_OK;
        pending.push_back(r);
      end
    endfunction

    function void note_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
      if (count < chull_pkg::MAX_POINTS) begin
        xs[count] = x;
        ys[count] = y;
        count++;
      end else overflow = 1;
      if (last) begin
        if (overflow) push_error(chull_pkg::STATUS_OVER);
        else if (count < chull_pkg::MIN_SET) push_error(chull_pkg::STATUS_FEW);
        else solve_hull();
        count = 0;
        overflow = 0;
      end
    endfunction

    task automatic report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task automatic check_result(hull_res_t got);
      hull_res_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = pending.pop_front();
      if (got.hull_index !== want.hull_index)
        report($sformatf("hull_index got %0d want %0d", got.hull_index, want.hull_index));
      if (got.hull_count !== want.hull_count)
        report($sformatf("hull_count got %0d want %0d", got.hull_count, want.hull_count));
      if (got.last_result !== want.last_result)
        report($sformatf("last_result got %0b want %0b", got.last_result, want.last_result));
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
    endtask
  endclass

  logic clk;
  logic rst;
  chull_in_if  in_ch();
  chull_out_if out_ch();
  hull_scoreboard board;
  bit calm;

  convex_hull_2d DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // one point transaction, with random idle before it
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
    while (!calm && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.px <= x;
    in_ch.py <= y;
    in_ch.last_point <= last;
    do @(posedge clk); while (!in_ch.ready);
    board.note_point(x, y, last);
    @(negedge clk);
  endtask

  task automatic send_set(int n, int span);
    for (int i = 0; i < n; i++)
      send_point(16'($urandom_range(2*span) - span), 16'($urandom_range(2*span) - span),
                 i == n-1);
  endtask

  // result sink with random stalls
  always @(negedge clk)
    out_ch.ready <= rst ? 1'b0 : (calm || $urandom_range(99) >= 10);

  always @(posedge clk)
    if (!rst && out_ch.valid && out_ch.ready)
      board.check_result('{out_ch.hull_index, out_ch.hull_count,
                           out_ch.last_result, out_ch.status});

  initial begin
    int n, rc;
    board = new();
    calm = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.px = '0;
    in_ch.py = '0;
    in_ch.last_point = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: too few, square extremes, collinear, duplicates, overflow
    send_point(16'sd5, 16'sd5, 1'b1);
    send_point(16'sd1, 16'sd2, 1'b0);
    send_point(16'sd3, 16'sd4, 1'b1);
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sd32767, 16'sh8000, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b0);
    send_point(16'sh8000, 16'sd32767, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd2, 16'sd2, 1'b0);
    send_point(16'sd1, 16'sd1, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd4, 16'sd0, 1'b0);
    send_point(16'sd2, 16'sd0, 1'b1);
    send_point(-16'sd1, -16'sd21846, 1'b0);
    send_point(16'sd21845, 16'sd1, 1'b0);
    send_point(-16'sd21846, 16'sd21845, 1'b1);
    send_set(64, 100);
    send_set(65, 100);

    // random sets, mostly small, a few full, a quiet stretch in the middle
    n = 0;
    for (int s = 0; n < 150; s++) begin
      calm = (s >= 10 && s < 20);
      rc = $urandom_range(99);
      if (rc < 5) begin
        send_set(64, 32767); n += 64;
      end else if (rc < 8) begin
        send_set(66, 32767); n += 66;
      end else if (rc < 14) begin
        rc = $urandom_range(2, 1);
        send_set(rc, 32767); n += rc;
      end else begin
        rc = $urandom_range(12, 3);
        send_set(rc, ($urandom_range(1)) ? 32767 : 4);
        n += rc;
      end
    end
    calm = 0;
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
